/* rtl/salb_pkg.sv */
// Package for the sorted adjacency list builder.
// Holds field widths, operation and status codes, and the controller state type.
// No dependencies.
`default_nettype none

package salb_pkg;

    // Fixed widths of the word fields and the configuration port.
    localparam int ACTION_W    = 2;
    localparam int VERTEX_IN_W = 8;
    localparam int QUERY_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int NEIGHBOR_W  = 4;
    localparam int VCOUNT_W    = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    // Reset values of the configuration registers.
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = VCOUNT_W'(16);
    localparam logic                DIRECTED_RESET = 1'b1;

    // Operation codes carried by an input word.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // Status codes carried by a result word.
    typedef enum logic [STATUS_W-1:0] {
        STS_STORED   = 3'd0,
        STS_IGNORED  = 3'd1,
        STS_OVERFLOW = 3'd2,
        STS_NEIGHBOR = 3'd3,
        STS_EMPTY    = 3'd4,
        STS_CLEARED  = 3'd5
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VERTEX_COUNT = 1'd0,
        CFG_DIRECTED     = 1'd1
    } cfg_index_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LEN,
        S_RD_STREAM,
        S_INS_LEN,
        S_INS_SHIFT,
        S_INS_PLACE,
        S_INS_NEXT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/salb_in_if.sv */
// Valid/ready channel interfaces for request and result words.
// Depends on salb_pkg for field widths and the status type.
`default_nettype none

interface salb_in_if import salb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [VERTEX_IN_W-1:0] edge_source;
    logic [VERTEX_IN_W-1:0] edge_target;
    logic [QUERY_W-1:0]     query_vertex;

    modport source (output valid, action, edge_source, edge_target, query_vertex,
                     input ready);
    modport sink   (input valid, action, edge_source, edge_target, query_vertex,
                     output ready);
endinterface

interface salb_out_if import salb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [NEIGHBOR_W-1:0] neighbor;
    logic                  last;

    modport source (output valid, status, neighbor, last, input ready);
    modport sink   (input valid, status, neighbor, last, output ready);
endinterface

`default_nettype wire

/* rtl/sorted_adjacency_list_builder_core.sv */
// Sorted adjacency list builder: per-vertex neighbor lists kept in ascending order.
// Depends on salb_pkg and the channel interfaces in salb_in_if.sv.
//
// Channel  Dir  Word fields
// in_ch    in   action, edge_source, edge_target, query_vertex
// out_ch   out  status, neighbor, last
// cfg      in   cfg_we, cfg_index, cfg_data (vertex_count, directed)
//
// One word is in work at a time; in_ch.ready is high only in the idle state.
// Add: the list length is read, then per insertion the entries above the new value shift up
// one slot each when the list is not empty, a reverse insertion follows in undirected mode, and
// the result is posted last.
// Read: the list length is read, then one word per neighbor; clear and ignored adds post at once.
// The neighbor memory has a single read port.
// Reset clears lengths at once through per-vertex valid bits; no clearing pass.
// A stalled out_ch holds the controller in place; a finished result waits in the
// output register while the next word can already be accepted.
`default_nettype none

module sorted_adjacency_list_builder_core
    import salb_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    salb_in_if.sink                     in_ch,
    salb_out_if.source                  out_ch
);

    localparam int VBW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int LW    = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH = MAX_VERTICES * (2 ** SW);
    localparam logic [VERTEX_IN_W:0] MAXV_EXT = (VERTEX_IN_W + 1)'(MAX_VERTICES);
    localparam logic [LW-1:0]        FULL_LEN = LW'(MAX_DEGREE);

    // Configuration registers.
    logic [VCOUNT_W-1:0] vertex_count_reg;
    logic                directed_reg;

    // Controller registers.
    state_t              state_reg, state_next;
    logic [VBW-1:0]      v_reg, v_next;
    logic [VBW-1:0]      val_reg, val_next;
    logic                pend2_reg, pend2_next;
    logic                fail_reg, fail_next;
    logic [SW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    status_t             status_reg, status_next;
    logic [MAX_VERTICES-1:0] len_valid_reg, len_valid_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [NEIGHBOR_W-1:0] out_neighbor_reg, out_neighbor_next;
    logic                  out_last_reg, out_last_next;

    // Memories: neighbor entries addressed {vertex, slot}, and list lengths.
    logic [VBW-1:0] nb_mem [0:DEPTH-1];
    logic [LW-1:0]  len_mem [0:MAX_VERTICES-1];
    logic [VBW-1:0] nb_rdata_reg;
    logic [LW-1:0]  len_rdata_reg;

    logic                nb_we, nb_re, len_we, len_re;
    logic [VBW+SW-1:0]   nb_waddr, nb_raddr;
    logic [VBW-1:0]      nb_wdata;
    logic [VBW-1:0]      len_waddr, len_raddr;
    logic [LW-1:0]       len_wdata;

    // Decode helpers.
    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic [VERTEX_IN_W:0] eff_count;
    logic                 edge_in_range;
    logic                 query_in_store;
    logic [LW-1:0]        cur_len;
    logic                 ins_done;
    logic                 ins_fail;

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign out_free        = !out_valid_reg || out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_status_reg;
    assign out_ch.neighbor = out_neighbor_reg;
    assign out_ch.last     = out_last_reg;

    // Effective vertex count and range checks on the incoming word.
    assign eff_count = ({4'd0, vertex_count_reg} > MAXV_EXT) ? MAXV_EXT
                     : {4'd0, vertex_count_reg};
    assign edge_in_range  = ({1'b0, in_ch.edge_source} < eff_count)
                         && ({1'b0, in_ch.edge_target} < eff_count);
    assign query_in_store = ((VERTEX_IN_W + 1)'(in_ch.query_vertex) < MAXV_EXT);

    // Length of the addressed list; an invalid entry reads as empty.
    assign cur_len = len_valid_reg[v_reg] ? len_rdata_reg : '0;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        if (nb_re)
        begin
            nb_rdata_reg <= nb_mem[nb_raddr];
        end
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_re)
        begin
            len_rdata_reg <= len_mem[len_raddr];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.action)
                        ACT_ADD:   state_next = edge_in_range ? S_INS_LEN : S_EMIT;
                        ACT_CLEAR: state_next = S_EMIT;
                        ACT_READ:  state_next = query_in_store ? S_RD_LEN : S_EMIT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_LEN:
            begin
                state_next = (cur_len == '0) ? S_EMIT : S_RD_STREAM;
            end
            S_RD_STREAM:
            begin
                if (out_free && (LW'(cnt_reg) + LW'(1) == len_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            S_INS_LEN:
            begin
                if (cur_len >= FULL_LEN || cur_len == '0)
                begin
                    state_next = pend2_reg ? S_INS_NEXT : S_EMIT;
                end
                else
                begin
                    state_next = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT:
            begin
                if (nb_rdata_reg > val_reg)
                begin
                    if (pos_reg == SW'(1))
                    begin
                        state_next = S_INS_PLACE;
                    end
                end
                else
                begin
                    state_next = pend2_reg ? S_INS_NEXT : S_EMIT;
                end
            end
            S_INS_PLACE:
            begin
                state_next = pend2_reg ? S_INS_NEXT : S_EMIT;
            end
            S_INS_NEXT:
            begin
                state_next = S_INS_LEN;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory strobes and result loading.
    always_comb
    begin
        v_next            = v_reg;
        val_next          = val_reg;
        pend2_next        = pend2_reg;
        fail_next         = fail_reg;
        pos_next          = pos_reg;
        len_next          = len_reg;
        cnt_next          = cnt_reg;
        status_next       = status_reg;
        len_valid_next    = len_valid_reg;
        out_load          = 1'b0;
        out_status_next   = out_status_reg;
        out_neighbor_next = out_neighbor_reg;
        out_last_next     = out_last_reg;
        nb_we             = 1'b0;
        nb_re             = 1'b0;
        nb_waddr          = {v_reg, pos_reg};
        nb_raddr          = {v_reg, pos_reg};
        nb_wdata          = val_reg;
        len_we            = 1'b0;
        len_re            = 1'b0;
        len_waddr         = v_reg;
        len_raddr         = v_reg;
        len_wdata         = cur_len + LW'(1);
        ins_done          = 1'b0;
        ins_fail          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.action)
                        ACT_ADD:
                        begin
                            if (edge_in_range)
                            begin
                                v_next     = VBW'(in_ch.edge_source);
                                val_next   = VBW'(in_ch.edge_target);
                                pend2_next = !directed_reg;
                                fail_next  = 1'b0;
                                len_re     = 1'b1;
                                len_raddr  = VBW'(in_ch.edge_source);
                            end
                            else
                            begin
                                status_next = STS_IGNORED;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            len_valid_next = '0;
                            status_next    = STS_CLEARED;
                        end
                        ACT_READ:
                        begin
                            if (query_in_store)
                            begin
                                v_next    = VBW'(in_ch.query_vertex);
                                len_re    = 1'b1;
                                len_raddr = VBW'(in_ch.query_vertex);
                            end
                            else
                            begin
                                status_next = STS_EMPTY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_LEN:
            begin
                if (cur_len == '0)
                begin
                    status_next = STS_EMPTY;
                end
                else
                begin
                    len_next = cur_len;
                    cnt_next = '0;
                    nb_re    = 1'b1;
                    nb_raddr = {v_reg, {SW{1'b0}}};
                end
            end
            S_RD_STREAM:
            begin
                // Hold the read data while the output is stalled.
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_status_next   = STS_NEIGHBOR;
                    out_neighbor_next = NEIGHBOR_W'(nb_rdata_reg);
                    out_last_next     = (LW'(cnt_reg) + LW'(1) == len_reg);
                    if (LW'(cnt_reg) + LW'(1) != len_reg)
                    begin
                        cnt_next = cnt_reg + SW'(1);
                        nb_re    = 1'b1;
                        nb_raddr = {v_reg, cnt_reg + SW'(1)};
                    end
                end
            end
            S_INS_LEN:
            begin
                if (cur_len >= FULL_LEN)
                begin
                    ins_fail = 1'b1;
                    ins_done = 1'b1;
                end
                else
                begin
                    len_we                = 1'b1;
                    len_valid_next[v_reg] = 1'b1;
                    if (cur_len == '0)
                    begin
                        nb_we    = 1'b1;
                        nb_waddr = {v_reg, {SW{1'b0}}};
                        ins_done = 1'b1;
                    end
                    else
                    begin
                        pos_next = SW'(cur_len);
                        nb_re    = 1'b1;
                        nb_raddr = {v_reg, SW'(cur_len - LW'(1))};
                    end
                end
            end
            S_INS_SHIFT:
            begin
                // Move the larger entry up one slot, or drop the value in place.
                nb_we = 1'b1;
                if (nb_rdata_reg > val_reg)
                begin
                    nb_wdata = nb_rdata_reg;
                    pos_next = pos_reg - SW'(1);
                    if (pos_reg != SW'(1))
                    begin
                        nb_re    = 1'b1;
                        nb_raddr = {v_reg, pos_reg - SW'(2)};
                    end
                end
                else
                begin
                    ins_done = 1'b1;
                end
            end
            S_INS_PLACE:
            begin
                nb_we    = 1'b1;
                ins_done = 1'b1;
            end
            S_INS_NEXT:
            begin
                // Reverse edge: swap the roles of the two vertices.
                v_next     = val_reg;
                val_next   = v_reg;
                pend2_next = 1'b0;
                len_re     = 1'b1;
                len_raddr  = val_reg;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_status_next   = status_reg;
                    out_neighbor_next = '0;
                    out_last_next     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (ins_fail)
        begin
            fail_next = 1'b1;
        end
        if (ins_done && !pend2_reg)
        begin
            status_next = (fail_reg || ins_fail) ? STS_OVERFLOW : STS_STORED;
        end

        out_valid_next = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pend2_reg        <= 1'b0;
            len_valid_reg    <= '0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= VCOUNT_RESET;
            directed_reg     <= DIRECTED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pend2_reg     <= pend2_next;
            len_valid_reg <= len_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_VERTEX_COUNT: vertex_count_reg <= VCOUNT_W'(cfg_data);
                    CFG_DIRECTED:     directed_reg     <= cfg_data[0];
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        v_reg            <= v_next;
        val_reg          <= val_next;
        fail_reg         <= fail_next;
        pos_reg          <= pos_next;
        len_reg          <= len_next;
        cnt_reg          <= cnt_next;
        status_reg       <= status_next;
        out_status_reg   <= out_status_next;
        out_neighbor_reg <= out_neighbor_next;
        out_last_reg     <= out_last_next;
    end

    // A list length never grows past the list capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_we |-> (len_wdata <= FULL_LEN))
        else $error("list length written beyond capacity");

    // The shift loop always has an entry below the current slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_SHIFT) |-> (pos_reg != '0))
        else $error("shift entered at slot zero");

    // No reverse insertion is left pending once the block is idle again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend2_reg)
        else $error("reverse insertion lost");

    // A result is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ch.ready))
        else $error("output register overwritten");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for sorted_adjacency_list_builder_core.
// Uses salb_pkg and the channel interfaces in rtl/salb_in_if.sv. A directed table runs first,
// then random phases under several register settings, all checked by an in-bench predictor.
`timescale 1ns / 1ps

module tb;
    import salb_pkg::*;

    localparam int NUM_VERTICES    = 16;
    localparam int DEGREE_LIMIT    = 16;
    localparam int SETTLE_CYCLES   = 48;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 6;
    localparam int WORDS_PER_PHASE = 80;
    localparam int REPORT_LIMIT    = 10;

    // Action code that the block does not define; it must be dropped silently.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One result word as it leaves the block.
    typedef struct packed {
        status_t               status;
        logic [NEIGHBOR_W-1:0] neighbor;
        logic                  last;
    } result_t;

    // One row of the directed table: register setting, input word and,
    // where it is obvious, the single status expected back.
    typedef struct packed {
        logic [VCOUNT_W-1:0]    vcount;
        logic                   directed;
        logic [ACTION_W-1:0]    action;
        logic [VERTEX_IN_W-1:0] src;
        logic [VERTEX_IN_W-1:0] dst;
        logic [QUERY_W-1:0]     query;
        logic                   typed;
        status_t                sts;
    } step_t;

    localparam int PLAN_LEN = 27;
    localparam step_t PLAN [PLAN_LEN] = '{
        // Empty store after reset, first inserts, duplicate and self-loop.
        '{5'd16, 1'b1, ACT_READ,   8'd0,   8'd0,   4'd0,  1'b1, STS_EMPTY},
        '{5'd16, 1'b1, ACT_ADD,    8'd0,   8'd15,  4'd0,  1'b1, STS_STORED},
        '{5'd16, 1'b1, ACT_ADD,    8'd0,   8'd3,   4'd0,  1'b1, STS_STORED},
        '{5'd16, 1'b1, ACT_ADD,    8'd0,   8'd3,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b1, ACT_ADD,    8'd0,   8'd0,   4'd0,  1'b0, STS_STORED},
        // Out of range vertices on either side, a read, an undefined action and a clear.
        '{5'd16, 1'b1, ACT_ADD,    8'd16,  8'd0,   4'd0,  1'b1, STS_IGNORED},
        '{5'd16, 1'b1, ACT_ADD,    8'd0,   8'd255, 4'd0,  1'b1, STS_IGNORED},
        '{5'd16, 1'b1, ACT_READ,   8'd0,   8'd0,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b1, ACT_UNUSED, 8'd255, 8'd255, 4'd15, 1'b0, STS_STORED},
        '{5'd16, 1'b1, ACT_CLEAR,  8'd0,   8'd0,   4'd0,  1'b1, STS_CLEARED},
        '{5'd16, 1'b1, ACT_READ,   8'd0,   8'd0,   4'd0,  1'b1, STS_EMPTY},
        // A vertex count of zero ignores everything; above the maximum it saturates.
        '{5'd0,  1'b1, ACT_ADD,    8'd0,   8'd0,   4'd0,  1'b1, STS_IGNORED},
        '{5'd31, 1'b1, ACT_ADD,    8'd15,  8'd15,  4'd0,  1'b1, STS_STORED},
        '{5'd31, 1'b1, ACT_ADD,    8'd15,  8'd16,  4'd0,  1'b1, STS_IGNORED},
        // Undirected self-loops fill vertex 7 two entries at a time.
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        // Full list: dropped alone, then dropped on one side of an undirected pair.
        '{5'd16, 1'b0, ACT_ADD,    8'd7,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_ADD,    8'd1,   8'd7,   4'd0,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_READ,   8'd0,   8'd0,   4'd7,  1'b0, STS_STORED},
        '{5'd16, 1'b0, ACT_READ,   8'd0,   8'd0,   4'd1,  1'b0, STS_STORED},
        // Lowering the vertex count leaves old lists readable.
        '{5'd1,  1'b1, ACT_READ,   8'd0,   8'd0,   4'd15, 1'b0, STS_STORED}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    salb_in_if  in_ch ();
    salb_out_if out_ch ();

    // Predictor state: neighbor lists, their lengths and the register copies.
    logic [NEIGHBOR_W-1:0] nbr_list [NUM_VERTICES][DEGREE_LIMIT];
    int                    nbr_count [NUM_VERTICES] = '{default: 0};
    logic [VCOUNT_W-1:0]   cfg_vcount   = VCOUNT_RESET;
    logic                  cfg_directed = DIRECTED_RESET;

    result_t predicted [$];
    result_t pending_results [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      sender_idles   = 1'b1;
    bit      receiver_idles = 1'b1;
    bit      long_hold_req  = 1'b0;

    sorted_adjacency_list_builder_core #(
        .MAX_VERTICES (NUM_VERTICES),
        .MAX_DEGREE   (DEGREE_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Inserts val into the list of vertex v in ascending order; returns 0 when full.
    function automatic bit insert_neighbor(int v, logic [NEIGHBOR_W-1:0] val);
        int pos;
        if (nbr_count[v] >= DEGREE_LIMIT)
            return 1'b0;
        pos = nbr_count[v];
        while (pos > 0 && nbr_list[v][pos-1] > val)
        begin
            nbr_list[v][pos] = nbr_list[v][pos-1];
            pos--;
        end
        nbr_list[v][pos] = val;
        nbr_count[v]++;
        return 1'b1;
    endfunction

    // Adds one word to the back of the prediction for the current input word.
    function automatic void predict_word(status_t sts, logic [NEIGHBOR_W-1:0] nb, logic lst);
        result_t w;
        w = '{sts, nb, lst};
        predicted.insert(predicted.size(), w);
    endfunction

    // Updates the predictor state for one accepted word and leaves its results in predicted.
    function automatic void predict_results(logic [ACTION_W-1:0] act,
                                            logic [VERTEX_IN_W-1:0] src,
                                            logic [VERTEX_IN_W-1:0] dst,
                                            logic [QUERY_W-1:0] qv);
        int limit;
        bit ok;
        predicted.delete();
        limit = (cfg_vcount > NUM_VERTICES) ? NUM_VERTICES : int'(cfg_vcount);
        case (act)
            ACT_ADD:
            begin
                if (src >= limit || dst >= limit)
                    predict_word(STS_IGNORED, 4'd0, 1'b1);
                else
                begin
                    ok = insert_neighbor(int'(src), dst[NEIGHBOR_W-1:0]);
                    if (!cfg_directed && !insert_neighbor(int'(dst), src[NEIGHBOR_W-1:0]))
                        ok = 1'b0;
                    if (ok)
                        predict_word(STS_STORED, 4'd0, 1'b1);
                    else
                        predict_word(STS_OVERFLOW, 4'd0, 1'b1);
                end
            end
            ACT_CLEAR:
            begin
                for (int v = 0; v < NUM_VERTICES; v++)
                    nbr_count[v] = 0;
                predict_word(STS_CLEARED, 4'd0, 1'b1);
            end
            ACT_READ:
            begin
                if (nbr_count[qv] == 0)
                    predict_word(STS_EMPTY, 4'd0, 1'b1);
                else
                    for (int k = 0; k < nbr_count[qv]; k++)
                        predict_word(STS_NEIGHBOR, nbr_list[qv][k],
                                     k == nbr_count[qv] - 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void log_mismatch(string what, result_t want_w, result_t got_w);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected status %0d neighbor %0d last %0d, %s %0d %s %0d %s %0d",
                     $time, what, want_w.status, want_w.neighbor, want_w.last,
                     "got status", got_w.status, "neighbor", got_w.neighbor,
                     "last", got_w.last);
    endfunction

    // Offers one word, waits for the handshake and records what it should produce.
    // Valid stays high afterwards so the next word can follow back to back.
    task automatic send_word(logic [ACTION_W-1:0] act, logic [VERTEX_IN_W-1:0] src,
                             logic [VERTEX_IN_W-1:0] dst, logic [QUERY_W-1:0] qv,
                             bit typed, status_t typed_sts);
        result_t typed_w;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.edge_source  <= src;
        in_ch.edge_target  <= dst;
        in_ch.query_vertex <= qv;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_results(act, src, dst, qv);
        if (typed)
        begin
            typed_w = '{typed_sts, 4'd0, 1'b1};
            pending_results.insert(pending_results.size(), typed_w);
        end
        else
            foreach (predicted[k])
                pending_results.insert(pending_results.size(), predicted[k]);
    endtask

    // Waits for the block to go idle, then writes both registers.
    task automatic program_registers(logic [VCOUNT_W-1:0] vc, logic dir);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_data  <= CFG_DATA_W'(vc);
        @(posedge clk);
        cfg_index <= CFG_DIRECTED;
        cfg_data  <= CFG_DATA_W'(dir);
        @(posedge clk);
        cfg_we       <= 1'b0;
        cfg_vcount   = vc;
        cfg_directed = dir;
    endtask

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial
    begin : result_receiver
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        result_t got_w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_w = '{out_ch.status, out_ch.neighbor, out_ch.last};
            if (pending_results.size() == 0)
                log_mismatch("result with none expected", '0, got_w);
            else if (got_w.status !== pending_results[0].status ||
                     got_w.neighbor !== pending_results[0].neighbor ||
                     got_w.last !== pending_results[0].last)
                log_mismatch("result mismatch", pending_results[0], got_w);
            if (pending_results.size() != 0)
                void'(pending_results.pop_front());
        end
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_adjacency_list_builder_core regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [ACTION_W-1:0]    act;
        logic [VERTEX_IN_W-1:0] src;
        logic [VERTEX_IN_W-1:0] dst;
        logic [QUERY_W-1:0]     qv;
        logic [VCOUNT_W-1:0]    vc;
        logic                   dir;
        int                     limit;
        int                     pick;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_VERTEX_COUNT;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_ADD;
        in_ch.edge_source  = '0;
        in_ch.edge_target  = '0;
        in_ch.query_vertex = '0;
        out_ch.ready       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; registers change only where a row asks for it.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].vcount != cfg_vcount || PLAN[i].directed != cfg_directed)
                program_registers(PLAN[i].vcount, PLAN[i].directed);
            send_word(PLAN[i].action, PLAN[i].src, PLAN[i].dst, PLAN[i].query,
                      PLAN[i].typed, PLAN[i].sts);
        end

        // Random phases; the first one starts with a long hold on the result side,
        // the last one runs without idling.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin vc = 5'd16; dir = 1'b0; end
                1: begin vc = 5'd2;  dir = 1'b0; end
                2: begin vc = 5'd31; dir = 1'b1; end
                3: begin vc = 5'd1;  dir = 1'b0; end
                4: begin vc = VCOUNT_W'($urandom_range(0, 31)); dir = 1'($urandom); end
                default: begin vc = 5'd16; dir = 1'b1; end
            endcase
            program_registers(vc, dir);
            if (p == 0)
                long_hold_req = 1'b1;
            if (p == NUM_PHASES - 1)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            limit = (cfg_vcount > NUM_VERTICES) ? NUM_VERTICES : int'(cfg_vcount);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                src  = VERTEX_IN_W'($urandom);
                dst  = VERTEX_IN_W'($urandom);
                qv   = QUERY_W'($urandom);
                if (pick < 60)
                begin
                    // Mostly edges inside the vertex range.
                    act = ACT_ADD;
                    if (limit > 0 && $urandom_range(0, 9) < 8)
                    begin
                        src = VERTEX_IN_W'($urandom_range(0, limit - 1));
                        dst = VERTEX_IN_W'($urandom_range(0, limit - 1));
                    end
                end
                else if (pick < 90)
                    act = ACT_READ;
                else if (pick < 94)
                    act = ACT_CLEAR;
                else if (pick < 97)
                    act = ACT_UNUSED;
                else
                    act = ACT_ADD;
                send_word(act, src, dst, qv, 1'b0, STS_STORED);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("sorted_adjacency_list_builder_core regression: pass");
        else
            $display("sorted_adjacency_list_builder_core regression: fail");
        $finish;
    end

endmodule
